[hdl/gasp_pkg.sv]
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared types, step tables and the octile heuristic of the grid path search.
// ----------------------------------------------------------------------------
package gasp_pkg;

  localparam int COORD_W = 3;
  localparam int COST_W  = 10;
  localparam int SUM_W   = 11;
  localparam int HEUR_W  = 7;
  localparam int EMIT_W  = 7;
  localparam logic [EMIT_W-1:0] MAX_EMIT = 7'd64;

  localparam logic [1:0] ST_UNSEEN = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_GOAL_X  = 2'd2;
  localparam logic [1:0] REG_GOAL_Y  = 2'd3;

  localparam logic ACT_LOAD = 1'b0;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'b01,
    OP_RELAX = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t               op;
    logic [COST_W-1:0]     a;
    logic [HEUR_W-1:0]     b;
    logic [SUM_W-1:0]      ref_f;
    logic [HEUR_W-1:0]     ref_h;
    logic                  any;
    logic [COST_W-1:0]     cmp_cost;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             better;
  } alu_rsp_t;

  // Column step of direction k (W, E, N, S, NW, SE, SW, NE), two's complement
  function automatic logic [3:0] step_dx(input logic [2:0] k);
    logic [3:0] d;
    case (k)
      3'd0, 3'd4, 3'd6: d = 4'hF;
      3'd1, 3'd5, 3'd7: d = 4'h1;
      default:          d = 4'h0;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] step_dy(input logic [2:0] k);
    logic [3:0] d;
    case (k)
      3'd2, 3'd4, 3'd7: d = 4'hF;
      3'd3, 3'd5, 3'd6: d = 4'h1;
      default:          d = 4'h0;
    endcase
    return d;
  endfunction

  function automatic logic [HEUR_W-1:0] step_cost(input logic [2:0] k);
    return k[2] ? 7'd14 : 7'd10;
  endfunction

  // Octile distance between two cells
  function automatic logic [HEUR_W-1:0] heur(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] gx,
                                             input logic [COORD_W-1:0] gy);
    logic [COORD_W-1:0] dx, dy, lo, hi;
    dx = (x > gx) ? x - gx : gx - x;
    dy = (y > gy) ? y - gy : gy - y;
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    return 7'd14 * {4'b0, lo} + 7'd10 * {4'b0, hi - lo};
  endfunction

endpackage

[hdl/gasp_ram.sv]
// ----------------------------------------------------------------------------
// gasp_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module gasp_ram #(
  parameter int W = 1,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/gasp_alu.sv]
// ----------------------------------------------------------------------------
// gasp_alu
// Shared adder and comparator: open-list f compare and neighbour relaxation.
// ----------------------------------------------------------------------------
module gasp_alu
  import gasp_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [SUM_W-1:0] sum;

  assign sum = {1'b0, req.a} + SUM_W'(req.b);

  // scan: strictly better f, tie to lower h; relax: stored cost drops
  always_comb begin
    rsp.sum = sum;
    case (req.op)
      OP_SCAN:  rsp.better = !req.any || (sum < req.ref_f) ||
                             ((sum == req.ref_f) && (req.b < req.ref_h));
      OP_RELAX: rsp.better = req.cmp_cost > sum[COST_W-1:0];
      default:  rsp.better = 1'b0;
    endcase
  end

endmodule

[hdl/grid_astar_path_search.sv]
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A load transaction writes its cell's blocked bit if the cell is in the grid.
// A run clears the status of every cell, then S_INIT; per expansion, S_EXRD
// and S_EXCHK per in-grid neighbour and S_EXRD per off-grid one, a scan of
// S_SCRD, S_SCCELL, S_SCCMP per opened cell, then S_SEL; path cells after the
// first take S_PTRD and S_PTNX, plus any output stall. in_tready stays low
// from a run until its final result. Reset: blocked map cleared (valid bits),
// registers to start 0,0 goal 7,7.
module grid_astar_path_search
  import gasp_pkg::*;
#(
  parameter int GRID_W = 8,
  parameter int GRID_H = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // cell_x[2:0], cell_y[5:3], blocked[6]
  input  logic [0:0] in_tuser,   // action[0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // path_x[2:0], path_y[5:3]
  output logic [0:0] out_tuser,  // found[0]
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [2:0] cfg_wdata
);

  localparam int NCELL = GRID_W * GRID_H;
  localparam int IDX_W = $clog2(NCELL);
  localparam int CNT_W = $clog2(NCELL + 1);
  localparam logic [3:0] GW = 4'(GRID_W);
  localparam logic [3:0] GH = 4'(GRID_H);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLR    = 12'b000000000010,
    S_INIT   = 12'b000000000100,
    S_EXRD   = 12'b000000001000,
    S_EXCHK  = 12'b000000010000,
    S_SCRD   = 12'b000000100000,
    S_SCCELL = 12'b000001000000,
    S_SCCMP  = 12'b000010000000,
    S_SEL    = 12'b000100000000,
    S_PTRD   = 12'b001000000000,
    S_PTNX   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  function automatic logic [IDX_W-1:0] cidx(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
    logic [6:0] t;
    t = 7'(y) * 7'(GRID_W) + 7'(x);
    return t[IDX_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [NCELL-1:0]   blk_vld_r;
  logic               blk_vq_r;

  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COST_W-1:0]  cur_cost_r, cur_cost_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [COORD_W-1:0] nb_x_r, nb_x_nxt, nb_y_r, nb_y_nxt;
  logic [CNT_W-1:0]   open_cnt_r, open_cnt_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [COORD_W-1:0] c_x_r, c_x_nxt, c_y_r, c_y_nxt;
  logic               any_r, any_nxt;
  logic [COORD_W-1:0] best_x_r, best_x_nxt, best_y_r, best_y_nxt;
  logic [SUM_W-1:0]   best_f_r, best_f_nxt;
  logic [HEUR_W-1:0]  best_h_r, best_h_nxt;
  logic [COST_W-1:0]  best_cost_r, best_cost_nxt;
  logic [EMIT_W-1:0]  emit_r, emit_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic               out_found_r, out_found_nxt, out_last_r, out_last_nxt;

  // memory ports
  logic               blk_we;
  logic [IDX_W-1:0]   blk_waddr, rd_addr;
  logic [0:0]         blk_q;
  logic               st_we;
  logic [IDX_W-1:0]   st_waddr;
  logic [1:0]         st_wdata, st_q;
  logic               cost_we;
  logic [IDX_W-1:0]   cost_waddr;
  logic [COST_W-1:0]  cost_wdata, cost_q;
  logic               par_we;
  logic [2:0]         par_q;
  logic               ord_we;
  logic [5:0]         ord_q;
  logic [IDX_W-1:0]   ord_raddr;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // clamped endpoints
  logic [COORD_W-1:0] sx, sy, gx, gy;
  assign sx = ({1'b0, start_x_r} >= GW) ? 3'(GRID_W - 1) : start_x_r;
  assign sy = ({1'b0, start_y_r} >= GH) ? 3'(GRID_H - 1) : start_y_r;
  assign gx = ({1'b0, goal_x_r} >= GW) ? 3'(GRID_W - 1) : goal_x_r;
  assign gy = ({1'b0, goal_y_r} >= GH) ? 3'(GRID_H - 1) : goal_y_r;

  logic [3:0] nx4, ny4, px4, py4;
  logic       nb_in, pt_term, load_ok, blocked_nb;
  logic [HEUR_W-1:0] c_h;

  assign nx4 = {1'b0, cur_x_r} + step_dx(k_r);
  assign ny4 = {1'b0, cur_y_r} + step_dy(k_r);
  assign nb_in = !nx4[3] && !ny4[3] && (nx4 < GW) && (ny4 < GH);
  assign px4 = {1'b0, out_x_r} - step_dx(par_q);
  assign py4 = {1'b0, out_y_r} - step_dy(par_q);
  assign pt_term = px4[3] || py4[3] || (px4 >= GW) || (py4 >= GH) ||
                   ((px4[2:0] == sx) && (py4[2:0] == sy));
  assign load_ok = ({1'b0, in_tdata[2:0]} < GW) && ({1'b0, in_tdata[5:3]} < GH);
  assign blocked_nb = blk_vq_r && blk_q[0];
  assign c_h = heur(c_x_r, c_y_r, gx, gy);

  assign in_tready = (state_r == S_IDLE);

  gasp_ram #(.W(1), .D(NCELL)) u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(in_tdata[6:6]),
    .raddr(rd_addr), .rdata(blk_q)
  );
  gasp_ram #(.W(2), .D(NCELL)) u_stat (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(rd_addr), .rdata(st_q)
  );
  gasp_ram #(.W(COST_W), .D(NCELL)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(rd_addr), .rdata(cost_q)
  );
  gasp_ram #(.W(3), .D(NCELL)) u_par (
    .clk(clk), .we(par_we), .waddr(cidx(nb_x_r, nb_y_r)), .wdata(k_r),
    .raddr(cidx(out_x_r, out_y_r)), .rdata(par_q)
  );
  gasp_ram #(.W(6), .D(NCELL)) u_ord (
    .clk(clk), .we(ord_we), .waddr(open_cnt_r[IDX_W-1:0]), .wdata({nb_y_r, nb_x_r}),
    .raddr(ord_raddr), .rdata(ord_q)
  );

  gasp_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_cost_nxt  = cur_cost_r;
    k_nxt         = k_r;
    nb_x_nxt      = nb_x_r;
    nb_y_nxt      = nb_y_r;
    open_cnt_nxt  = open_cnt_r;
    scan_nxt      = scan_r;
    c_x_nxt       = c_x_r;
    c_y_nxt       = c_y_r;
    any_nxt       = any_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    best_f_nxt    = best_f_r;
    best_h_nxt    = best_h_r;
    best_cost_nxt = best_cost_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    blk_we     = 1'b0;
    blk_waddr  = cidx(in_tdata[2:0], in_tdata[5:3]);
    rd_addr    = cidx(nx4[2:0], ny4[2:0]);
    st_we      = 1'b0;
    st_waddr   = cidx(nb_x_r, nb_y_r);
    st_wdata   = ST_OPEN;
    cost_we    = 1'b0;
    cost_waddr = cidx(nb_x_r, nb_y_r);
    cost_wdata = alu_rsp.sum[COST_W-1:0];
    par_we     = 1'b0;
    ord_we     = 1'b0;
    ord_raddr  = scan_r[IDX_W-1:0];

    alu_req.op       = OP_RELAX;
    alu_req.a        = cur_cost_r;
    alu_req.b        = step_cost(k_r);
    alu_req.ref_f    = best_f_r;
    alu_req.ref_h    = best_h_r;
    alu_req.any      = any_r;
    alu_req.cmp_cost = cost_q;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == ACT_LOAD) begin
            blk_we = load_ok;
          end else begin
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end
        end
      end
      // clear the status of every cell
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = ST_UNSEEN;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == IDX_W'(NCELL - 1)) begin
          state_nxt = S_INIT;
        end
      end
      // close the start cell with cost zero
      S_INIT: begin
        st_we        = 1'b1;
        st_waddr     = cidx(sx, sy);
        st_wdata     = ST_CLOSED;
        cost_we      = 1'b1;
        cost_waddr   = cidx(sx, sy);
        cost_wdata   = '0;
        open_cnt_nxt = '0;
        if ((sx == gx) && (sy == gy)) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = sx;
          out_y_nxt     = sy;
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cur_x_nxt    = sx;
          cur_y_nxt    = sy;
          cur_cost_nxt = '0;
          k_nxt        = '0;
          state_nxt    = S_EXRD;
        end
      end
      // fetch one neighbour, skip off-grid ones
      S_EXRD: begin
        nb_x_nxt = nx4[2:0];
        nb_y_nxt = ny4[2:0];
        if (nb_in) begin
          state_nxt = S_EXCHK;
        end else if (k_r == 3'd7) begin
          scan_nxt  = '0;
          any_nxt   = 1'b0;
          state_nxt = S_SCRD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // open or relax the neighbour
      S_EXCHK: begin
        if (!blocked_nb) begin
          if (st_q == ST_UNSEEN) begin
            cost_we      = 1'b1;
            par_we       = 1'b1;
            st_we        = 1'b1;
            ord_we       = 1'b1;
            open_cnt_nxt = open_cnt_r + 1'b1;
          end else if (alu_rsp.better) begin
            cost_we = 1'b1;
            par_we  = 1'b1;
          end
        end
        if (k_r == 3'd7) begin
          scan_nxt  = '0;
          any_nxt   = 1'b0;
          state_nxt = S_SCRD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_EXRD;
        end
      end
      S_SCRD: begin
        if (scan_r >= open_cnt_r) begin
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_SCCELL;
        end
      end
      S_SCCELL: begin
        c_x_nxt   = ord_q[2:0];
        c_y_nxt   = ord_q[5:3];
        rd_addr   = cidx(ord_q[2:0], ord_q[5:3]);
        state_nxt = S_SCCMP;
      end
      // keep the best open cell
      S_SCCMP: begin
        alu_req.op = OP_SCAN;
        alu_req.a  = cost_q;
        alu_req.b  = c_h;
        if ((st_q == ST_OPEN) && alu_rsp.better) begin
          any_nxt       = 1'b1;
          best_x_nxt    = c_x_r;
          best_y_nxt    = c_y_r;
          best_f_nxt    = alu_rsp.sum;
          best_h_nxt    = c_h;
          best_cost_nxt = cost_q;
        end
        scan_nxt  = scan_r + 1'b1;
        state_nxt = S_SCRD;
      end
      S_SEL: begin
        st_waddr = cidx(best_x_r, best_y_r);
        st_wdata = ST_CLOSED;
        out_x_nxt = sx;
        out_y_nxt = sy;
        if (!any_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          st_we = 1'b1;
          if ((best_x_r == gx) && (best_y_r == gy)) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            emit_nxt      = 7'd2;
            state_nxt     = S_OUT;
          end else begin
            cur_x_nxt    = best_x_r;
            cur_y_nxt    = best_y_r;
            cur_cost_nxt = best_cost_r;
            k_nxt        = '0;
            state_nxt    = S_EXRD;
          end
        end
      end
      // pending path cell sits in the output fields with valid low
      S_PTRD: begin
        if (emit_r == MAX_EMIT) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_PTNX;
        end
      end
      S_PTNX: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = pt_term;
        state_nxt     = S_OUT;
      end
      // hold the transaction until taken, then advance
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PTRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // path bookkeeping: after start goes out load goal, after a step load parent
  logic [COORD_W-1:0] pend_x, pend_y;
  logic               pend_load;
  logic               first_r;

  assign pend_load = (state_r == S_OUT) && out_tready && !out_last_r;
  assign pend_x = first_r ? gx : px4[2:0];
  assign pend_y = first_r ? gy : py4[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      open_cnt_r  <= '0;
      blk_vld_r   <= '0;
      start_x_r   <= 3'd0;
      start_y_r   <= 3'd0;
      goal_x_r    <= 3'd7;
      goal_y_r    <= 3'd7;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      open_cnt_r  <= open_cnt_nxt;
      if (blk_we) begin
        blk_vld_r[blk_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_START_X: start_x_r <= cfg_wdata;
          REG_START_Y: start_y_r <= cfg_wdata;
          REG_GOAL_X:  goal_x_r  <= cfg_wdata;
          REG_GOAL_Y:  goal_y_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_SEL) begin
        first_r <= 1'b1;
      end else if (pend_load) begin
        first_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    clr_r       <= clr_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    cur_cost_r  <= cur_cost_nxt;
    k_r         <= k_nxt;
    nb_x_r      <= nb_x_nxt;
    nb_y_r      <= nb_y_nxt;
    scan_r      <= scan_nxt;
    c_x_r       <= c_x_nxt;
    c_y_r       <= c_y_nxt;
    any_r       <= any_nxt;
    best_x_r    <= best_x_nxt;
    best_y_r    <= best_y_nxt;
    best_f_r    <= best_f_nxt;
    best_h_r    <= best_h_nxt;
    best_cost_r <= best_cost_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    blk_vq_r    <= blk_vld_r[rd_addr];
    if (pend_load) begin
      out_x_r <= pend_x;
      out_y_r <= pend_y;
      emit_r  <= first_r ? emit_r : emit_r + 1'b1;
    end else begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_y_r, out_x_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  // a result is only shown while the sequencer waits for it
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == S_OUT))
    else $error("result valid outside output wait");

  // the final transaction of a run frees the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not ready after final result");

  // no more cells opened than the grid holds
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_cnt_r <= CNT_W'(NCELL))
    else $error("open count beyond grid size");

endmodule
